// File: rtl/p2d_pkg.sv
package p2d_pkg;

  typedef logic [15:0] word_t;
  typedef logic [1:0]  status_t;
  typedef logic [3:0]  bit_pos_t;

  localparam logic OP_ENCODE  = 1'b0;
  localparam logic OP_CORRECT = 1'b1;

  localparam status_t ST_CLEAN = 2'd0;
  localparam status_t ST_FIXED = 2'd1;
  localparam status_t ST_FAIL  = 2'd2;

  // bit position of each grid cell, row-major; column 3 and row 3 hold parity
  localparam bit_pos_t GRID_POS [4][4] = '{
    '{4'h8, 4'h7, 4'h6, 4'hb},
    '{4'h5, 4'h4, 4'h3, 4'ha},
    '{4'h2, 4'h1, 4'h0, 4'h9},
    '{4'hc, 4'hd, 4'he, 4'hf}
  };

endpackage

// File: rtl/p2d_codec.sv
module p2d_codec
  import p2d_pkg::*;
(
  input  logic    op,
  input  word_t   data_word,
  output word_t   result_word,
  output status_t status
);

  word_t       enc_w;
  logic        enc_p;
  logic  [3:0] row_even;
  logic  [3:0] col_even;
  logic  [1:0] row_idx;
  logic  [1:0] col_idx;
  logic        row_one;
  logic        col_one;
  word_t       fixed_w;

  // encode: row parity first, then column parity over the completed rows
  always_comb begin
    enc_w = {7'd0, data_word[8:0]};
    for (int r = 0; r < 3; r++) begin
      enc_p = 1'b0;
      for (int c = 0; c < 3; c++) begin
        enc_p = enc_p ^ enc_w[GRID_POS[r][c]];
      end
      enc_w[GRID_POS[r][3]] = ~enc_p;
    end
    for (int c = 0; c < 4; c++) begin
      enc_p = 1'b0;
      for (int r = 0; r < 3; r++) begin
        enc_p = enc_p ^ enc_w[GRID_POS[r][c]];
      end
      enc_w[GRID_POS[3][c]] = ~enc_p;
    end
  end

  // syndrome: a group with even parity has failed
  always_comb begin
    row_idx = 2'd0;
    col_idx = 2'd0;
    for (int k = 0; k < 4; k++) begin
      row_even[k] = 1'b1;
      col_even[k] = 1'b1;
      for (int j = 0; j < 4; j++) begin
        row_even[k] = row_even[k] ^ data_word[GRID_POS[k][j]];
        col_even[k] = col_even[k] ^ data_word[GRID_POS[j][k]];
      end
      if (row_even[k]) begin
        row_idx = 2'(k);
      end
      if (col_even[k]) begin
        col_idx = 2'(k);
      end
    end
  end

  assign row_one = (row_even != 4'd0) && ((row_even & (row_even - 4'd1)) == 4'd0);
  assign col_one = (col_even != 4'd0) && ((col_even & (col_even - 4'd1)) == 4'd0);

  always_comb begin
    fixed_w = data_word;
    fixed_w[GRID_POS[row_idx][col_idx]] = ~data_word[GRID_POS[row_idx][col_idx]];
  end

  always_comb begin
    unique case (op)
      OP_ENCODE: begin
        result_word = {9'd0, enc_w[15:9]};
        status      = ST_CLEAN;
      end
      OP_CORRECT: begin
        priority if ((row_even == 4'd0) && (col_even == 4'd0)) begin
          result_word = data_word;
          status      = ST_CLEAN;
        end else if (row_one && col_one) begin
          result_word = fixed_w;
          status      = ST_FIXED;
        end else begin
          result_word = '0;
          status      = ST_FAIL;
        end
      end
      default: begin
        result_word = '0;
        status      = ST_FAIL;
      end
    endcase
  end

endmodule

// File: rtl/parity_2d_3x3_encode_correct_unit.sv
// path: an input transaction passes the input register, then the result register, before out_tvalid
// throughput: one transaction per cycle while out_tready does not stall; parity/correct logic is combinational
// input register frees as soon as it moves on; while a result waits, input is taken only if it is empty
// reset: synchronous active-low rst_n clears both valid flags; payload is not reset
module parity_2d_3x3_encode_correct_unit
  import p2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [15:0] in_tdata,   // data_word[15:0]
  input  logic       in_tuser,    // op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [15:0] out_tdata,  // result_word[15:0]
  output logic [1:0] out_tuser    // status[1:0]
);

  logic    s1_valid_r;
  logic    s1_op_r;
  word_t   s1_data_r;
  logic    out_valid_r;
  word_t   out_word_r;
  status_t out_status_r;
  logic    s1_adv;
  word_t   res_word;
  status_t res_status;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  p2d_codec u_codec (
    .op          (s1_op_r),
    .data_word   (s1_data_r),
    .result_word (res_word),
    .status      (res_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_data_r <= in_tdata;
    end
    if (s1_adv && s1_valid_r) begin
      out_word_r   <= res_word;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_status_r;

endmodule

// File: tb/sv/parity_2d_3x3_encode_correct_unit_tb.sv
module parity_2d_3x3_encode_correct_unit_tb;
  import p2d_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 700;

  typedef struct packed {
    logic    op;
    word_t   din;
    word_t   word;
    status_t status;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // data_word[15:0]
  logic        in_tuser = 1'b0; // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // result_word[15:0]
  logic [1:0]  out_tuser;       // status[1:0]

  outcome_t outcome_q[$];
  bit       idle_on = 1'b1;
  int       stall_left = 0;
  int       idle_cycles = 0;
  int       mismatches = 0;
  int       n_encode = 0;
  int       n_clean = 0;
  int       n_fixed = 0;
  int       n_fail = 0;

  parity_2d_3x3_encode_correct_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic word_t encode_parity(word_t d);
    word_t cw;
    logic  p;
    cw = d & 16'h01ff;
    for (int r = 0; r < 3; r++) begin
      p = 1'b0;
      for (int c = 0; c < 3; c++) p ^= cw[GRID_POS[r][c]];
      if (!p) cw[GRID_POS[r][3]] = 1'b1;
    end
    for (int c = 0; c < 4; c++) begin
      p = 1'b0;
      for (int r = 0; r < 3; r++) p ^= cw[GRID_POS[r][c]];
      if (!p) cw[GRID_POS[3][c]] = 1'b1;
    end
    return cw >> 9;
  endfunction

  function automatic word_t make_codeword(word_t d);
    return (d & 16'h01ff) | (encode_parity(d) << 9);
  endfunction

  function automatic outcome_t predict_outcome(logic op, word_t w);
    outcome_t res;
    int       even_rows;
    int       even_cols;
    int       row_at;
    int       col_at;
    logic     pr;
    logic     pc;
    res.op = op;
    res.din = w;
    even_rows = 0;
    even_cols = 0;
    row_at = 0;
    col_at = 0;
    if (op == OP_ENCODE) begin
      res.word = encode_parity(w);
      res.status = ST_CLEAN;
      return res;
    end
    for (int k = 0; k < 4; k++) begin
      pr = 1'b0;
      pc = 1'b0;
      for (int j = 0; j < 4; j++) begin
        pr ^= w[GRID_POS[k][j]];
        pc ^= w[GRID_POS[j][k]];
      end
      if (!pr) begin
        even_rows++;
        row_at = k;
      end
      if (!pc) begin
        even_cols++;
        col_at = k;
      end
    end
    if (even_rows == 0 && even_cols == 0) begin
      res.word = w;
      res.status = ST_CLEAN;
    end else if (even_rows == 1 && even_cols == 1) begin
      res.word = w ^ (16'h0001 << GRID_POS[row_at][col_at]);
      res.status = ST_FIXED;
    end else begin
      res.word = '0;
      res.status = ST_FAIL;
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, outcome_t want, word_t got);
    mismatches++;
    $display("mismatch %s: op %0d word %h expected %h got %h", field, want.op,
             want.din, (field == "status") ? want.status : want.word, got);
  endtask

  task automatic send_item(input logic op, input word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tuser <= op;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    outcome_q.push_back(predict_outcome(op, w));
    @(posedge clk);
  endtask

  // ready side with random stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      int n;
      n = pick_gap();
      if (n == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left <= n - 1;
      end
    end
  end

  always @(negedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("unexpected transaction: word %h status %0d", out_tdata, out_tuser);
      end else begin
        want = outcome_q.pop_front();
        if (out_tdata !== want.word) report_mismatch("result_word", want, out_tdata);
        if (out_tuser !== want.status) report_mismatch("status", want, word_t'(out_tuser));
        if (want.op == OP_ENCODE) n_encode++;
        else if (want.status == ST_CLEAN) n_clean++;
        else if (want.status == ST_FIXED) n_fixed++;
        else n_fail++;
      end
    end
  end

  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("parity_2d_3x3_encode_correct_unit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic test_encode_directed();
    send_item(OP_ENCODE, 16'h0000);
    send_item(OP_ENCODE, 16'h01ff);
    for (int i = 0; i < 9; i++) send_item(OP_ENCODE, 16'h0001 << i);
    // upper bits must be ignored
    send_item(OP_ENCODE, 16'hfe00);
    send_item(OP_ENCODE, 16'hffff);
    send_item(OP_ENCODE, 16'ha955);
  endtask

  task automatic test_correct_directed();
    word_t cw;
    cw = make_codeword(16'h00ab);
    send_item(OP_CORRECT, cw);
    send_item(OP_CORRECT, cw ^ 16'h0010);
    send_item(OP_CORRECT, cw ^ 16'h0800);
    send_item(OP_CORRECT, cw ^ 16'h2000);
    send_item(OP_CORRECT, cw ^ 16'h8000);
    // same row, same column, diagonal, three flips
    send_item(OP_CORRECT, cw ^ 16'h0180);
    send_item(OP_CORRECT, cw ^ 16'h0104);
    send_item(OP_CORRECT, cw ^ 16'h0110);
    send_item(OP_CORRECT, cw ^ 16'h0111);
    send_item(OP_CORRECT, 16'h0000);
    send_item(OP_CORRECT, 16'hffff);
  endtask

  task automatic test_random_traffic();
    word_t w;
    int    pick;
    int    a;
    int    b;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = ((i / 100) % 3) != 2;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_item(OP_ENCODE, word_t'($urandom()));
      end else begin
        w = make_codeword(word_t'($urandom()));
        pick = $urandom_range(0, 99);
        a = $urandom_range(0, 15);
        b = (a + $urandom_range(1, 15)) % 16;
        if (pick < 45) w ^= 16'h0001 << a;
        else if (pick < 70) w ^= (16'h0001 << a) | (16'h0001 << b);
        else if (pick < 85) w = word_t'($urandom());
        send_item(OP_CORRECT, w);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_directed();
    test_correct_directed();
    test_random_traffic();
    in_tvalid <= 1'b0;
    wait (outcome_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d encodes and %0d checked words: %0d clean, %0d repaired, %0d rejected",
             n_encode, n_clean + n_fixed + n_fail, n_clean, n_fixed, n_fail);
    $display("mismatches seen: %0d", mismatches);
    if (mismatches == 0) begin
      $display("parity_2d_3x3_encode_correct_unit_tb: PASS");
    end else begin
      $display("parity_2d_3x3_encode_correct_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
